FILE: design/rtt_pkg.sv
// Package for the request tag tracker: action and event codes, controller states,
// and the command and status structs between the controller and the datapath.
// No dependencies.
`default_nettype none

package rtt_pkg;

  // Input actions, carried in in_tuser.
  localparam logic [1:0] ACT_REQUEST  = 2'd0;
  localparam logic [1:0] ACT_RESPONSE = 2'd1;
  localparam logic [1:0] ACT_TICK     = 2'd2;
  localparam logic [1:0] ACT_RELEASE  = 2'd3;

  // Result events, carried in out_tuser.
  localparam logic [2:0] EV_GRANTED   = 3'd0;
  localparam logic [2:0] EV_NO_TAG    = 3'd1;
  localparam logic [2:0] EV_MATCHED   = 3'd2;
  localparam logic [2:0] EV_UNMATCHED = 3'd3;
  localparam logic [2:0] EV_TIMED_OUT = 3'd4;
  localparam logic [2:0] EV_RELEASED  = 3'd5;
  localparam logic [2:0] EV_NOT_REG   = 3'd6;
  localparam logic [2:0] EV_TICK_DONE = 3'd7;

  // Configuration register indexes.
  localparam logic CFG_DEFAULT_TIMEOUT = 1'b0;
  localparam logic CFG_TICK_PERIOD     = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [15:0] DEFAULT_TIMEOUT_RST = 16'd5000;
  localparam logic [15:0] TICK_PERIOD_RST     = 16'd1000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_RESP_RD,
    ST_RESP_CMP,
    ST_REL,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       cap;       // capture the input item and set up the pointer
    logic       grant;     // take the tag at the pointer and write its entry
    logic       clr_busy;  // free the tag at the pointer
    logic       adv;       // step the pointer (and probe count) with wrap
    logic       emit;      // load the output register
    logic [2:0] ev;        // event code of the emitted item
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] action;      // action of the item offered at the input
    logic       probe_free;  // tag at the pointer is free
    logic       probe_last;  // this probe is the last one of the search
    logic       scan_last;   // pointer is at the highest tag
    logic       scan_hit;    // entry at the pointer is busy and expired
    logic       resp_match;  // response matches the entry at the pointer
    logic       rel_hit;     // release names a busy tag
    logic       out_free;    // output register can take an item
  } dp_status_t;

endpackage

`default_nettype wire

FILE: design/request_tag_tracker_unit.sv
// Request tag tracker: tracks outstanding requests by instance tag with timeouts.
// Input items carry an action in in_tuser; each item gives one result item, a tick
// gives one timed-out item per expired entry and then a done item (out_tlast high
// on the final result of an item).
// One item is worked at a time; in_tready is high only while no item is in work.
// Steps per item, counted from acceptance to the last result loaded:
//   request:  one busy bit probed per cycle from the pointer
//   response: one entry RAM read, then compare
//   release:  check of the named tag, then its result
//   tick:     each entry read through the entry RAM port, then checked
// A stalled output register holds the block in a step that loads a result until
// taken; a finished result may wait there while the next item is accepted.
// Reset (synchronous, rst_n low) frees all tags, zeroes the tag pointer and the
// clock and restores the register defaults; entry RAM contents are not cleared.
// Configuration writes through cfg_we, cfg_index and cfg_wdata take effect at once.
`default_nettype none

module request_tag_tracker_unit import rtt_pkg::*; #(
  parameter int TAG_COUNT = 32,
  parameter int TIME_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // tag_in[4:0], msg_kind[10:5], command[18:11],
                                       // wait_ms[34:19], zero fill
  input  wire logic [1:0]  in_tuser,   // action[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // tag_out[4:0], kind_out[10:5],
                                       // command_out[18:11], zero fill
  output logic [2:0]       out_tuser,  // event_res[2:0]
  output logic             out_tlast,  // last
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  dp_cmd_t    cmd;
  dp_status_t st;

  rtt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .st       (st),
    .cmd      (cmd)
  );

  rtt_dp #(.TAG_COUNT(TAG_COUNT), .TIME_BITS(TIME_BITS)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .st         (st)
  );

`ifndef SYNTH
  // An accepted item keeps the block busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted again right after an item");

  // A result is only loaded when the output register is free.
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_tvalid || out_tready))
    else $error("output register overwritten");

  // The tick done item always closes its run.
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == EV_TICK_DONE |-> out_tlast)
    else $error("tick done without last");
`endif

endmodule

`default_nettype wire

FILE: design/rtt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rtt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: design/rtt_ctrl.sv
// Controller state machine of the request tag tracker.
// Depends on rtt_pkg for states, codes and the command and status structs.
`default_nettype none

module rtt_ctrl import rtt_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire dp_status_t st,
  output dp_cmd_t         cmd
);

  state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (st.action)
            ACT_REQUEST:  state_nxt = ST_SEARCH;
            ACT_RESPONSE: state_nxt = ST_RESP_RD;
            ACT_TICK:     state_nxt = ST_SCAN_RD;
            default:      state_nxt = ST_REL;
          endcase
        end
      end
      ST_SEARCH: begin
        if ((st.probe_free || st.probe_last) && st.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RESP_RD:  state_nxt = ST_RESP_CMP;
      ST_RESP_CMP: if (st.out_free) state_nxt = ST_IDLE;
      ST_REL:      if (st.out_free) state_nxt = ST_IDLE;
      ST_SCAN_RD:  state_nxt = ST_SCAN_CHK;
      ST_SCAN_CHK: begin
        if (!st.scan_hit || st.out_free) begin
          state_nxt = st.scan_last ? ST_DONE : ST_SCAN_RD;
        end
      end
      ST_DONE:     if (st.out_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Outputs. No item is taken while reset is held.
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = rst_n;
        cmd.cap  = in_valid && rst_n;
      end
      ST_SEARCH: begin
        if (st.probe_free) begin
          if (st.out_free) begin
            cmd.grant = 1'b1;
            cmd.emit  = 1'b1;
            cmd.ev    = EV_GRANTED;
          end
        end else if (st.probe_last) begin
          if (st.out_free) begin
            cmd.emit = 1'b1;
            cmd.ev   = EV_NO_TAG;
          end
        end else begin
          cmd.adv = 1'b1;
        end
      end
      ST_RESP_CMP: begin
        if (st.out_free) begin
          cmd.emit     = 1'b1;
          cmd.clr_busy = st.resp_match;
          cmd.ev       = st.resp_match ? EV_MATCHED : EV_UNMATCHED;
        end
      end
      ST_REL: begin
        if (st.out_free) begin
          cmd.emit     = 1'b1;
          cmd.clr_busy = st.rel_hit;
          cmd.ev       = st.rel_hit ? EV_RELEASED : EV_NOT_REG;
        end
      end
      ST_SCAN_CHK: begin
        if (st.scan_hit) begin
          if (st.out_free) begin
            cmd.emit     = 1'b1;
            cmd.clr_busy = 1'b1;
            cmd.ev       = EV_TIMED_OUT;
            cmd.adv      = !st.scan_last;
          end
        end else begin
          cmd.adv = !st.scan_last;
        end
      end
      ST_DONE: begin
        if (st.out_free) begin
          cmd.emit = 1'b1;
          cmd.ev   = EV_TICK_DONE;
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: design/rtt_dp.sv
// Datapath of the request tag tracker: item registers, busy map, pointers, clock,
// configuration registers, entry RAM and the output register.
// Depends on rtt_pkg and rtt_ram.
`default_nettype none

module rtt_dp import rtt_pkg::*; #(
  parameter int TAG_COUNT = 32,
  parameter int TIME_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [39:0] in_tdata,
  input  wire logic [1:0]  in_tuser,
  input  wire logic        out_tready,
  output logic             out_tvalid,
  output logic [23:0]      out_tdata,
  output logic [2:0]       out_tuser,
  output logic             out_tlast,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_wdata,
  input  wire dp_cmd_t     cmd,
  output dp_status_t       st
);

  localparam int TAG_W = $clog2(TAG_COUNT);
  localparam int ENT_W = 6 + 8 + TIME_BITS;
  localparam logic [TAG_W-1:0] TAG_LAST = TAG_W'(TAG_COUNT - 1);

  // Input fields.
  logic [4:0]  f_tag;
  logic [5:0]  f_kind;
  logic [7:0]  f_cmd;
  logic [15:0] f_wait;
  logic [6:0]  f_tag_ext;
  assign f_tag     = in_tdata[4:0];
  assign f_kind    = in_tdata[10:5];
  assign f_cmd     = in_tdata[18:11];
  assign f_wait    = in_tdata[34:19];
  assign f_tag_ext = {2'b00, f_tag};

  // Registers.
  logic [4:0]           tag_r;
  logic [5:0]           kind_r;
  logic [7:0]           cmd_r;
  logic [15:0]          wait_r;
  logic                 in_range_r;
  logic [TAG_COUNT-1:0] busy_r;
  logic [TAG_W-1:0]     ptr_r, cnt_r, next_tag_r;
  logic [TIME_BITS-1:0] clock_r;
  logic [15:0]          dflt_r, period_r;
  logic                 out_valid_r;
  logic [2:0]           out_ev_r;
  logic [4:0]           out_tag_r;
  logic [5:0]           out_kind_r;
  logic [7:0]           out_cmd_r;

  // Entry RAM: kind, command and expiry of each tag.
  logic [ENT_W-1:0]     wr_ent, rd_ent;
  logic [5:0]           rd_kind;
  logic [7:0]           rd_cmd;
  logic [TIME_BITS-1:0] rd_exp;
  assign rd_kind = rd_ent[5:0];
  assign rd_cmd  = rd_ent[13:6];
  assign rd_exp  = rd_ent[ENT_W-1:14];

  rtt_ram #(.WIDTH(ENT_W), .DEPTH(TAG_COUNT)) u_ram (
    .clk   (clk),
    .we    (cmd.grant),
    .waddr (ptr_r),
    .wdata (wr_ent),
    .raddr (ptr_r),
    .rdata (rd_ent)
  );

  // Saturating sums for the clock advance and the expiry time.
  logic [TIME_BITS:0]   clk_sum, exp_sum;
  logic [TIME_BITS-1:0] clk_sat, exp_sat;
  logic [15:0]          timeout;
  assign timeout = (wait_r != 16'd0) ? wait_r : dflt_r;
  assign clk_sum = {1'b0, clock_r} + (TIME_BITS + 1)'(period_r);
  assign exp_sum = {1'b0, clock_r} + (TIME_BITS + 1)'(timeout);
  assign clk_sat = clk_sum[TIME_BITS] ? '1 : clk_sum[TIME_BITS-1:0];
  assign exp_sat = exp_sum[TIME_BITS] ? '1 : exp_sum[TIME_BITS-1:0];
  assign wr_ent  = {exp_sat, cmd_r, kind_r};

  // Pointer step with wrap.
  logic [TAG_W-1:0] ptr_inc;
  assign ptr_inc = (ptr_r == TAG_LAST) ? '0 : ptr_r + 1'b1;

  // Status toward the controller.
  logic busy_ptr;
  assign busy_ptr      = busy_r[ptr_r];
  assign st.action     = in_tuser;
  assign st.probe_free = !busy_ptr;
  assign st.probe_last = (cnt_r == TAG_LAST);
  assign st.scan_last  = (ptr_r == TAG_LAST);
  assign st.scan_hit   = busy_ptr && (rd_exp <= clock_r);
  assign st.resp_match = in_range_r && busy_ptr && (rd_kind == kind_r) && (rd_cmd == cmd_r);
  assign st.rel_hit    = in_range_r && busy_ptr;
  assign st.out_free   = !out_valid_r || out_tready;

  // Control state: busy map, pointers, clock and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= '0;
      next_tag_r <= '0;
      ptr_r      <= '0;
      cnt_r      <= '0;
      clock_r    <= '0;
      dflt_r     <= DEFAULT_TIMEOUT_RST;
      period_r   <= TICK_PERIOD_RST;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_DEFAULT_TIMEOUT: dflt_r   <= cfg_wdata;
          CFG_TICK_PERIOD:     period_r <= cfg_wdata;
          default:             dflt_r   <= cfg_wdata;
        endcase
      end
      if (cmd.cap) begin
        cnt_r <= '0;
        unique case (in_tuser)
          ACT_REQUEST: ptr_r <= next_tag_r;
          ACT_TICK: begin
            ptr_r   <= '0;
            clock_r <= clk_sat;
          end
          default: ptr_r <= f_tag_ext[TAG_W-1:0];
        endcase
      end
      if (cmd.adv) begin
        ptr_r <= ptr_inc;
        cnt_r <= cnt_r + 1'b1;
      end
      if (cmd.grant) begin
        busy_r[ptr_r] <= 1'b1;
        next_tag_r    <= ptr_inc;
      end
      if (cmd.clr_busy) begin
        busy_r[ptr_r] <= 1'b0;
      end
    end
  end

  // Item registers.
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      tag_r      <= f_tag;
      kind_r     <= f_kind;
      cmd_r      <= f_cmd;
      wait_r     <= f_wait;
      in_range_r <= (f_tag_ext < 7'(TAG_COUNT));
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output payload by event.
  logic [6:0] ptr_ext, next_ext;
  assign ptr_ext  = 7'(ptr_r);
  assign next_ext = 7'(next_tag_r);

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_ev_r   <= cmd.ev;
      out_kind_r <= 6'd0;
      out_cmd_r  <= 8'd0;
      case (cmd.ev) inside
        EV_GRANTED, EV_TIMED_OUT: out_tag_r <= ptr_ext[4:0];
        EV_NO_TAG:                out_tag_r <= next_ext[4:0];
        EV_TICK_DONE:             out_tag_r <= 5'd0;
        default:                  out_tag_r <= tag_r;
      endcase
      if (cmd.ev == EV_MATCHED || cmd.ev == EV_TIMED_OUT) begin
        out_kind_r <= rd_kind;
        out_cmd_r  <= rd_cmd;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_ev_r;
  assign out_tlast  = (out_ev_r != EV_TIMED_OUT);
  assign out_tdata  = {5'd0, out_cmd_r, out_kind_r, out_tag_r};

endmodule

`default_nettype wire
